// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every rising clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/s256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Word and state types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package s256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hstate_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;
  localparam logic [7:0]  PadMarker  = 8'h80;

  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// File: design/s256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, purely combinational.
// ----------------------------------------------------------------------------
module s256_round (
  input  s256_pkg::hstate_t state_i,
  input  s256_pkg::word_t   k_i,
  input  s256_pkg::word_t   w0_i,
  input  s256_pkg::word_t   w1_i,
  input  s256_pkg::word_t   w9_i,
  input  s256_pkg::word_t   w14_i,
  output s256_pkg::hstate_t state_o,
  output s256_pkg::word_t   w_new_o
);
  import s256_pkg::*;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  word_t e1, ch, t1, a0, mj, t2, g0, g1;

  always_comb begin
    e1 = rotr(state_i[4], 6) ^ rotr(state_i[4], 11) ^ rotr(state_i[4], 25);
    ch = (state_i[4] & state_i[5]) ^ (~state_i[4] & state_i[6]);
    t1 = state_i[7] + e1 + ch + k_i + w0_i;
    a0 = rotr(state_i[0], 2) ^ rotr(state_i[0], 13) ^ rotr(state_i[0], 22);
    mj = (state_i[0] & state_i[1]) ^ (state_i[0] & state_i[2]) ^
         (state_i[1] & state_i[2]);
    t2 = a0 + mj;

    state_o[7] = state_i[6];
    state_o[6] = state_i[5];
    state_o[5] = state_i[4];
    state_o[4] = state_i[3] + t1;
    state_o[3] = state_i[2];
    state_o[2] = state_i[1];
    state_o[1] = state_i[0];
    state_o[0] = t1 + t2;

    g0 = rotr(w1_i, 7) ^ rotr(w1_i, 18) ^ (w1_i >> 3);
    g1 = rotr(w14_i, 17) ^ rotr(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = w0_i + g0 + w9_i + g1;
  end

endmodule

// File: design/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message that arrives one byte per transaction and returns the
// 256-bit digest as eight 32-bit words, most significant word first, the
// eighth marked with tlast. A data byte is taken while the block is idle.
// The byte that completes a 64-byte block starts a compression on the
// single round unit, one round per cycle, followed by an update of the
// eight chaining words. A finish transaction pads the message one byte per
// cycle, pausing while a block is compressed and once before the length
// bytes, runs one or two compressions and then presents the eight digest
// words, one per accepted output transaction. After the last word the block
// starts a new message from the initial hash values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_byte_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_number
  output logic        m_axis_tlast_o    // last_word
);
  import s256_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    PAD_MARK = 3'b001,
    PAD_ZERO = 3'b010,
    PAD_LEN  = 3'b100
  } pad_e;

  state_e        state_q, state_d;
  pad_e          pad_q, pad_d;
  logic [5:0]    fill_q, fill_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [63:0]   msg_q, msg_d;
  logic [63:0]   len_q, len_d;
  logic          fin_q, fin_d;
  logic [511:0]  buf_q, buf_d;
  hstate_t       h_q, h_d;
  hstate_t       s_q, s_d;

  logic          s_fire, m_fire, last_word;
  logic          push_en;
  logic [7:0]    push_byte, len_byte;
  hstate_t       round_state;
  word_t         w_new;

  s256_round u_round (
    .state_i (s_q),
    .k_i     (RoundK[cnt_q]),
    .w0_i    (buf_q[511:480]),
    .w1_i    (buf_q[479:448]),
    .w9_i    (buf_q[223:192]),
    .w14_i   (buf_q[63:32]),
    .state_o (round_state),
    .w_new_o (w_new)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign last_word       = (cnt_q[2:0] == 3'd7);
  assign m_axis_tdata_o  = {5'b00000, cnt_q[2:0], h_q[0]};
  assign m_axis_tlast_o  = last_word;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire          = m_axis_tvalid_o & m_axis_tready_i;
  assign len_byte        = len_q[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    state_d   = state_q;
    pad_d     = pad_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    msg_d     = msg_q;
    len_d     = len_q;
    fin_d     = fin_q;
    buf_d     = buf_q;
    h_d       = h_q;
    s_d       = s_q;
    push_en   = 1'b0;
    push_byte = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == KindFinish) begin
            len_d   = {msg_q[60:0], 3'b000};
            msg_d   = '0;
            fin_d   = 1'b1;
            pad_d   = PAD_MARK;
            state_d = ST_PAD;
          end else begin
            msg_d     = msg_q + 64'd1;
            push_en   = 1'b1;
            push_byte = s_axis_tdata_i;
          end
        end
      end
      ST_PAD: begin
        unique case (pad_q)
          PAD_MARK: begin
            push_en   = 1'b1;
            push_byte = PadMarker;
            pad_d     = PAD_ZERO;
          end
          PAD_ZERO: begin
            if (fill_q == 6'(LengthPos)) begin
              pad_d = PAD_LEN;
            end else begin
              push_en = 1'b1;
            end
          end
          PAD_LEN: begin
            push_en   = 1'b1;
            push_byte = len_byte;
          end
          default: pad_d = PAD_MARK;
        endcase
      end
      ST_ROUND: begin
        s_d   = round_state;
        buf_d = {buf_q[479:0], w_new};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(BlockBytes - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        h_d   = {h_q[0] + s_q[0], h_q[7:1]};
        s_d   = {s_q[0], s_q[7:1]};
        cnt_d = cnt_q + 6'd1;
        if (last_word) begin
          cnt_d = '0;
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (pad_q == PAD_LEN) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (m_fire) begin
          h_d   = {InitH[cnt_q[2:0]], h_q[7:1]};
          cnt_d = cnt_q + 6'd1;
          if (last_word) begin
            cnt_d   = '0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push_en) begin
      buf_d  = {buf_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'(BlockBytes - 1)) begin
        s_d     = h_q;
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= PAD_MARK;
      fill_q  <= '0;
      cnt_q   <= '0;
      msg_q   <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitH[i];
      end
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      msg_q   <= msg_d;
      fin_q   <= fin_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    buf_q <= buf_d;
    s_q   <= s_d;
  end

  `ASSERT_ALWAYS(a_ready_excl_valid, !(s_axis_tready_o && m_axis_tvalid_o), "ready and valid both high")
  `ASSERT_ALWAYS(a_round_empty_buf, (state_q != ST_ROUND) || (fill_q == 6'd0), "round with part-filled buffer")
  `ASSERT_ALWAYS(a_emit_needs_finish, (state_q != ST_EMIT) || (fin_q && pad_q == PAD_LEN), "digest without finish")
  `ASSERT_NEXT(a_last_then_ready, m_fire && m_axis_tlast_o, s_axis_tready_o && (msg_q == 64'd0), "no restart after digest")

endmodule
